// File: sv/itf_pkg.sv
// Shared types, constants and the arctangent table of the tilt filter.
package itf_pkg;

	localparam int CORDIC_ITERS = 16;
	localparam int MAX_ITERS = 24;
	localparam int NITER = (CORDIC_ITERS > MAX_ITERS) ? MAX_ITERS : CORDIC_ITERS;
	localparam int SQRT_STEPS = 23;
	localparam int DIV_STEPS = 3;
	localparam int CNT_W = 6;
	localparam int DCNT_W = 2;
	localparam logic signed [24:0] ANGLE_90 = 25'sd5898240;
	localparam logic [16:0] ALPHA_ONE = 17'd65536;
	localparam logic [16:0] ALPHA_RESET = 17'd62259;
	localparam logic [9:0] DIV_K = 10'd1000;
	// ceil(2^35 / 1000): exact quotient for any dividend below 2^25
	localparam logic [25:0] DIV_RECIP = 26'd34359739;

	typedef enum logic [2:0] {
		REG_ACCEL_RANGE,
		REG_GYRO_RANGE,
		REG_BLEND_ALPHA,
		REG_ACCEL_BIAS_X,
		REG_ACCEL_BIAS_Y,
		REG_ACCEL_BIAS_Z,
		REG_GYRO_BIAS_X,
		REG_GYRO_BIAS_Y
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCALE,
		ST_SQUARE,
		ST_SUM,
		ST_SQRT,
		ST_CINIT,
		ST_CORDIC,
		ST_WAIT,
		ST_INTEG,
		ST_BMUL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic scale;
		logic square;
		logic sum;
		logic sqrt_step;
		logic cinit;
		logic cordic_step;
		logic integ;
		logic bmul;
		logic commit;
		logic [CNT_W-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic out_busy;
	} sts_t;

	function automatic logic [22:0] atan_deg(input logic [4:0] i);
		case (i)
			5'd0: return 23'd2949120;
			5'd1: return 23'd1740967;
			5'd2: return 23'd919879;
			5'd3: return 23'd466945;
			5'd4: return 23'd234379;
			5'd5: return 23'd117304;
			5'd6: return 23'd58666;
			5'd7: return 23'd29335;
			5'd8: return 23'd14668;
			5'd9: return 23'd7334;
			5'd10: return 23'd3667;
			5'd11: return 23'd1833;
			5'd12: return 23'd917;
			5'd13: return 23'd458;
			5'd14: return 23'd229;
			5'd15: return 23'd115;
			5'd16: return 23'd57;
			5'd17: return 23'd29;
			5'd18: return 23'd14;
			5'd19: return 23'd7;
			5'd20: return 23'd4;
			5'd21: return 23'd2;
			5'd22: return 23'd1;
			default: return 23'd0;
		endcase
	endfunction

endpackage

// File: sv/itf_ctrl.sv
// Sequencer of the tilt filter: steps the datapath through one sample.
module itf_ctrl import itf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic last_sqrt, last_cordic;

	assign last_sqrt = (cnt_q == CNT_W'(SQRT_STEPS - 1));
	assign last_cordic = (cnt_q == CNT_W'(NITER - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_SQRT && !last_sqrt) || (state_q == ST_CORDIC && !last_cordic))
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_SCALE;
			ST_SCALE:  state_d = ST_SQUARE;
			ST_SQUARE: state_d = ST_SUM;
			ST_SUM:    state_d = ST_SQRT;
			ST_SQRT:   if (last_sqrt) state_d = ST_CINIT;
			ST_CINIT:  state_d = ST_CORDIC;
			ST_CORDIC: if (last_cordic) state_d = ST_WAIT;
			ST_WAIT:   if (!sts.div_busy) state_d = ST_INTEG;
			ST_INTEG:  state_d = ST_BMUL;
			ST_BMUL:   state_d = ST_DONE;
			ST_DONE:   if (!sts.out_busy) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.step = cnt_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SCALE:  cmd.scale = 1'b1;
			ST_SQUARE: cmd.square = 1'b1;
			ST_SUM:    cmd.sum = 1'b1;
			ST_SQRT:   cmd.sqrt_step = 1'b1;
			ST_CINIT:  cmd.cinit = 1'b1;
			ST_CORDIC: cmd.cordic_step = 1'b1;
			ST_INTEG:  cmd.integ = 1'b1;
			ST_BMUL:   cmd.bmul = 1'b1;
			ST_DONE:   cmd.commit = !sts.out_busy;
			default: ;
		endcase
	end

endmodule

// File: sv/itf_dp.sv
// Datapath of the tilt filter: scaling, square roots, CORDIC, divider, blend, output register.
module itf_dp import itf_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [27:0]  cfg_wdata,
	input  logic [95:0]  in_data,
	input  cmd_t         cmd,
	output sts_t         sts,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [111:0] out_data
);

	// configuration
	logic [1:0] accel_range_q, gyro_range_q;
	logic [16:0] blend_alpha_q;
	logic signed [21:0] abias_q [3];
	logic signed [27:0] gbias_q [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_range_q <= '0;
			gyro_range_q <= '0;
			blend_alpha_q <= ALPHA_RESET;
			for (int i = 0; i < 3; i++) abias_q[i] <= '0;
			for (int i = 0; i < 2; i++) gbias_q[i] <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_ACCEL_RANGE:  accel_range_q <= cfg_wdata[1:0];
				REG_GYRO_RANGE:   gyro_range_q <= cfg_wdata[1:0];
				REG_BLEND_ALPHA:  blend_alpha_q <= cfg_wdata[16:0];
				REG_ACCEL_BIAS_X: abias_q[0] <= cfg_wdata[21:0];
				REG_ACCEL_BIAS_Y: abias_q[1] <= cfg_wdata[21:0];
				REG_ACCEL_BIAS_Z: abias_q[2] <= cfg_wdata[21:0];
				REG_GYRO_BIAS_X:  gbias_q[0] <= cfg_wdata;
				REG_GYRO_BIAS_Y:  gbias_q[1] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// raw sample
	logic signed [15:0] raw_a_q [3];
	logic signed [15:0] raw_g_q [2];
	logic [15:0] ms_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < 3; i++) raw_a_q[i] <= in_data[16*i +: 16];
			for (int i = 0; i < 2; i++) raw_g_q[i] <= in_data[48 + 16*i +: 16];
			ms_q <= in_data[95:80];
		end
	end

	// scaling
	logic [2:0] ash;
	logic [1:0] gsh;
	logic signed [28:0] gmul [2];
	logic signed [22:0] acc_q [3];
	logic signed [28:0] rate_q [2];

	always_comb begin
		case (accel_range_q)
			2'd0: ash = 3'd2;
			2'd1: ash = 3'd5;
			2'd2: ash = 3'd3;
			default: ash = 3'd4;
		endcase
		gsh = gyro_range_q;
		for (int i = 0; i < 2; i++)
			gmul[i] = (29'(raw_g_q[i]) * 29'sd500) <<< gsh;
	end

	always_ff @(posedge clk) begin
		if (cmd.scale) begin
			for (int i = 0; i < 3; i++)
				acc_q[i] <= (23'(raw_a_q[i]) <<< ash) - 23'(abias_q[i]);
			for (int i = 0; i < 2; i++)
				rate_q[i] <= gmul[i] - 29'(gbias_q[i]);
		end
	end

	// squares and rate times step
	logic signed [45:0] sq [3];
	logic signed [44:0] gp [2];
	logic [44:0] sq_q [3];
	logic signed [44:0] gp_q [2];

	always_comb begin
		for (int i = 0; i < 3; i++) sq[i] = 46'(acc_q[i]) * 46'(acc_q[i]);
		for (int i = 0; i < 2; i++) gp[i] = 45'(rate_q[i]) * 45'($signed({1'b0, ms_q}));
	end

	always_ff @(posedge clk) begin
		if (cmd.square) begin
			for (int i = 0; i < 3; i++) sq_q[i] <= sq[i][44:0];
			for (int i = 0; i < 2; i++) gp_q[i] <= gp[i];
		end
	end

	// lane 0 is roll (num ay, den of ax and az), lane 1 is pitch (num ax, den of ay and az)
	logic [44:0] v_q [2];
	logic [44:0] res_q [2];
	logic [44:0] sbit;
	logic [44:0] trial [2];

	assign sbit = 45'(1) << (6'd44 - {cmd.step[4:0], 1'b0});

	always_comb begin
		for (int l = 0; l < 2; l++) trial[l] = res_q[l] + sbit;
	end

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			v_q[0] <= sq_q[0] + sq_q[2];
			v_q[1] <= sq_q[1] + sq_q[2];
			res_q[0] <= '0;
			res_q[1] <= '0;
		end else if (cmd.sqrt_step) begin
			for (int l = 0; l < 2; l++) begin
				if (v_q[l] >= trial[l]) begin
					v_q[l] <= v_q[l] - trial[l];
					res_q[l] <= (res_q[l] >> 1) + sbit;
				end else begin
					res_q[l] <= res_q[l] >> 1;
				end
			end
		end
	end

	// CORDIC vectoring
	logic signed [33:0] x_q [2];
	logic signed [33:0] y_q [2];
	logic signed [24:0] z_q [2];
	logic nz_q [2];
	logic signed [22:0] num [2];
	logic signed [24:0] dz;
	logic signed [33:0] xs [2];
	logic signed [33:0] ys [2];

	assign num[0] = acc_q[1];
	assign num[1] = acc_q[0];
	assign dz = $signed({2'b00, atan_deg(cmd.step[4:0])});

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			xs[l] = x_q[l] >>> cmd.step[4:0];
			ys[l] = y_q[l] >>> cmd.step[4:0];
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 2; l++) begin
			if (cmd.cinit) begin
				x_q[l] <= $signed({3'b000, res_q[l][22:0], 8'h00});
				y_q[l] <= $signed({{3{num[l][22]}}, num[l], 8'h00});
				z_q[l] <= '0;
				nz_q[l] <= (num[l] != '0);
			end else if (cmd.cordic_step) begin
				if (!y_q[l][33]) begin
					x_q[l] <= x_q[l] + ys[l];
					y_q[l] <= y_q[l] - xs[l];
					z_q[l] <= z_q[l] + dz;
				end else begin
					x_q[l] <= x_q[l] - ys[l];
					y_q[l] <= y_q[l] + xs[l];
					z_q[l] <= z_q[l] - dz;
				end
			end
		end
	end

	logic signed [23:0] ang [2];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			if (!nz_q[l])
				ang[l] = '0;
			else if (z_q[l] > ANGLE_90)
				ang[l] = ANGLE_90[23:0];
			else if (z_q[l] < -ANGLE_90)
				ang[l] = 24'(-ANGLE_90);
			else
				ang[l] = z_q[l][23:0];
		end
	end

	// round(rate * ms / 1000): long division of magnitude plus half, 15-bit digit per cycle
	logic [44:0] dvd_q [2];
	logic [45:0] dd_q [2];
	logic [9:0] rem_q [2];
	logic neg_q [2];
	logic [DCNT_W-1:0] dcnt_q;
	logic [24:0] part [2];
	logic [50:0] qprod [2];
	logic [14:0] qdig [2];
	logic [24:0] qrem [2];
	logic [44:0] gmag [2];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			gmag[l] = gp_q[l][44] ? 45'(-gp_q[l]) : gp_q[l];
			part[l] = {rem_q[l], dvd_q[l][44:30]};
			qprod[l] = 51'(part[l]) * 51'(DIV_RECIP);
			qdig[l] = qprod[l][49:35];
			qrem[l] = part[l] - 25'(qdig[l]) * 25'(DIV_K);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.sum) begin
			dcnt_q <= DCNT_W'(DIV_STEPS);
		end else if (dcnt_q != '0) begin
			dcnt_q <= dcnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 2; l++) begin
			if (cmd.sum) begin
				neg_q[l] <= gp_q[l][44];
				dvd_q[l] <= gmag[l] + 45'd500;
				rem_q[l] <= '0;
				dd_q[l] <= '0;
			end else if (dcnt_q != '0) begin
				dvd_q[l] <= {dvd_q[l][29:0], 15'd0};
				rem_q[l] <= qrem[l][9:0];
				dd_q[l] <= {dd_q[l][30:0], qdig[l]};
			end
		end
	end

	// integrate, blend, commit
	logic signed [31:0] est_q [2];
	logic signed [31:0] r_q [2];
	logic signed [46:0] inc [2];
	logic signed [46:0] tsum [2];
	logic [16:0] alpha;
	logic signed [50:0] p1 [2];
	logic signed [50:0] p2 [2];
	logic signed [50:0] bsum_q [2];
	logic signed [50:0] bmag [2];
	logic signed [31:0] bres [2];

	assign alpha = (blend_alpha_q > ALPHA_ONE) ? ALPHA_ONE : blend_alpha_q;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			inc[l] = neg_q[l] ? -$signed({1'b0, dd_q[l]}) : $signed({1'b0, dd_q[l]});
			tsum[l] = 47'(est_q[l]) + inc[l];
			p1[l] = 51'($signed({1'b0, alpha})) * 51'(r_q[l]);
			p2[l] = 51'($signed({1'b0, 17'(ALPHA_ONE - alpha)})) * 51'(ang[l]);
			if (!bsum_q[l][50]) begin
				bmag[l] = (bsum_q[l] + 51'sd32768) >>> 16;
				bres[l] = bmag[l][31:0];
			end else begin
				bmag[l] = (-bsum_q[l] + 51'sd32768) >>> 16;
				bres[l] = -bmag[l][31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 2; l++) begin
			if (cmd.integ) begin
				if (tsum[l] > 47'sd2147483647)
					r_q[l] <= 32'sh7FFFFFFF;
				else if (tsum[l] < -47'sd2147483648)
					r_q[l] <= 32'sh80000000;
				else
					r_q[l] <= tsum[l][31:0];
			end
			if (cmd.bmul)
				bsum_q[l] <= p1[l] + p2[l];
		end
	end

	logic out_valid_q;
	logic [111:0] out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q[0] <= '0;
			est_q[1] <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				est_q[0] <= bres[0];
				est_q[1] <= bres[1];
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit)
			out_data_q <= {ang[1], ang[0], bres[1], bres[0]};
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;
	assign sts.div_busy = (dcnt_q != '0);
	assign sts.out_busy = out_valid_q && !out_ready;

endmodule

// File: sv/imu_complementary_tilt_filter.sv
// Top level of the complementary roll and pitch tilt filter.
// Usage:
//  Write the range codes, blend weight and biases on the cfg_we / cfg_index / cfg_wdata
//  port while the block is idle; each write lands at the clock edge it is presented.
//  Send one raw sample per request on the s_axis group; one result per sample leaves
//  on the m_axis group with filtered roll and pitch and the accelerometer-only angles.
//  A sample runs through scale, square, sum, the 23-step square root, CORDIC init,
//  the 16-step CORDIC, a wait for the divider, integrate, blend and commit; the divide
//  by 1000 of the gyro increment takes 3 steps and runs alongside the square root.
//  One sample is processed at a time; s_axis_tready is high only while waiting for one.
//  The result sits in an output register: the next sample is accepted and worked on
//  while it waits, and the block holds the following result until the old one is taken.
//  Reset clears the estimates to zero, the registers to their defaults (weight 0.95)
//  and drops any pending result.
module imu_complementary_tilt_filter import itf_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [27:0]  cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// accel_x, accel_y, accel_z, gyro_x, gyro_y, elapsed_ms
	input  logic [95:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// roll_angle, pitch_angle, accel_roll, accel_pitch
	output logic [111:0] m_axis_tdata
);

	cmd_t cmd;
	sts_t sts;

	itf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	itf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_data   (s_axis_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

// File: sv/itf_chk.sv
// Port-level checks of the tilt filter, bound to the top level.
module itf_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [111:0] m_axis_tdata
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second request taken while busy");

	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(m_axis_tdata[87:64]) <= 24'sd5898240 &&
			$signed(m_axis_tdata[87:64]) >= -24'sd5898240))
		else $error("accel roll beyond 90 degrees");

endmodule

bind imu_complementary_tilt_filter itf_chk u_chk (.*);

// File: test/imu_complementary_tilt_filter_tb.sv
// Self-checking testbench for the complementary tilt filter: directed and random samples and settings.
`timescale 1ns / 1ps
module imu_complementary_tilt_filter_tb;
	import itf_pkg::*;

	typedef struct packed {
		logic [15:0] elapsed_ms;
		logic signed [15:0] gyro_y;
		logic signed [15:0] gyro_x;
		logic signed [15:0] accel_z;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_x;
	} sample_t;

	typedef struct packed {
		logic signed [23:0] accel_pitch;
		logic signed [23:0] accel_roll;
		logic signed [31:0] pitch_angle;
		logic signed [31:0] roll_angle;
	} tilt_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [27:0] cfg_wdata = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [95:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [111:0] m_axis_tdata;

	imu_complementary_tilt_filter u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #5 clk = ~clk;

	// predictor copy of registers and estimates
	logic [1:0] p_arange, p_grange;
	logic [16:0] p_alpha;
	longint p_abias[3];
	longint p_gbias[2];
	longint roll_est, pitch_est;

	sample_t sample_q[$];
	tilt_t tilt_q[$];
	int errors = 0;
	bit quiet = 0;       // no idling on either side
	int hold_cycles = 0; // long receiver hold-off
	int tx_gap = 0, rx_gap = 0;

	function automatic longint round_1000(longint n);
		if (n >= 0) return (n + 500) / 1000;
		return -((-n + 500) / 1000);
	endfunction

	function automatic longint round_q16(longint n);
		if (n >= 0) return (n + 32768) / 65536;
		return -((-n + 32768) / 65536);
	endfunction

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint floor_sqrt(longint v);
		longint lo, hi, mid;
		lo = 0;
		hi = 64'sd3037000499;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (mid * mid <= v) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	function automatic longint cordic_tilt(longint num, longint den);
		longint x, y, z, xs, ys;
		if (num == 0) return 0;
		x = den * 256;
		y = num * 256;
		z = 0;
		for (int i = 0; i < NITER; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys; y = y - xs; z = z + longint'(atan_deg(5'(i)));
			end else begin
				x = x - ys; y = y + xs; z = z - longint'(atan_deg(5'(i)));
			end
		end
		if (z > 5898240) z = 5898240;
		if (z < -5898240) z = -5898240;
		return z;
	endfunction

	function automatic longint mix(longint est, longint acc);
		longint a;
		a = (p_alpha > 17'd65536) ? 65536 : longint'(p_alpha);
		return round_q16(a * est + (65536 - a) * acc);
	endfunction

	function automatic tilt_t predict_tilt(sample_t s);
		longint am, gm, ax, ay, az, gx, gy, ar, ap, r, p;
		tilt_t t;
		case (p_arange)
			2'd0: am = 4; 2'd1: am = 32; 2'd2: am = 8; default: am = 16;
		endcase
		case (p_grange)
			2'd0: gm = 500; 2'd1: gm = 1000; 2'd2: gm = 2000; default: gm = 4000;
		endcase
		ax = longint'(s.accel_x) * am - p_abias[0];
		ay = longint'(s.accel_y) * am - p_abias[1];
		az = longint'(s.accel_z) * am - p_abias[2];
		gx = longint'(s.gyro_x) * gm - p_gbias[0];
		gy = longint'(s.gyro_y) * gm - p_gbias[1];
		ar = cordic_tilt(ay, floor_sqrt(ax * ax + az * az));
		ap = cordic_tilt(ax, floor_sqrt(ay * ay + az * az));
		r = clip32(roll_est + round_1000(gx * longint'(s.elapsed_ms)));
		p = clip32(pitch_est + round_1000(gy * longint'(s.elapsed_ms)));
		roll_est = mix(r, ar);
		pitch_est = mix(p, ap);
		t.roll_angle = roll_est[31:0];
		t.pitch_angle = pitch_est[31:0];
		t.accel_roll = ar[23:0];
		t.accel_pitch = ap[23:0];
		return t;
	endfunction

	// driver
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			tilt_q.push_back(predict_tilt(sample_t'(s_axis_tdata)));
		end
		if (!s_axis_tvalid || s_axis_tready) begin
			if (tx_gap > 0) begin
				tx_gap <= tx_gap - 1;
				s_axis_tvalid <= 1'b0;
			end else if (sample_q.size() > 0 && arst_n) begin
				s_axis_tdata <= sample_q.pop_front();
				s_axis_tvalid <= 1'b1;
				if (!quiet && $urandom_range(0, 15) == 0) tx_gap <= $urandom_range(1, 18);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// monitor and receiver stalls
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			tilt_t got, want;
			got = tilt_t'(m_axis_tdata);
			if (tilt_q.size() == 0) begin
				$error("result with nothing expected: %h", m_axis_tdata);
				errors++;
			end else begin
				want = tilt_q.pop_front();
				if (got.roll_angle !== want.roll_angle) begin
					$error("roll_angle exp %0d got %0d", want.roll_angle, got.roll_angle);
					errors++;
				end
				if (got.pitch_angle !== want.pitch_angle) begin
					$error("pitch_angle exp %0d got %0d", want.pitch_angle, got.pitch_angle);
					errors++;
				end
				if (got.accel_roll !== want.accel_roll) begin
					$error("accel_roll exp %0d got %0d", want.accel_roll, got.accel_roll);
					errors++;
				end
				if (got.accel_pitch !== want.accel_pitch) begin
					$error("accel_pitch exp %0d got %0d", want.accel_pitch, got.accel_pitch);
					errors++;
				end
			end
		end
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_axis_tready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap <= rx_gap - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if (!quiet && $urandom_range(0, 12) == 0) rx_gap <= $urandom_range(1, 18);
		end
	end

	task automatic wait_drained();
		while (sample_q.size() > 0 || s_axis_tvalid || tilt_q.size() > 0) @(posedge clk);
		// settle before touching the registers
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [27:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ACCEL_RANGE: p_arange = val[1:0];
			REG_GYRO_RANGE: p_grange = val[1:0];
			REG_BLEND_ALPHA: p_alpha = val[16:0];
			REG_ACCEL_BIAS_X: p_abias[0] = longint'($signed(val[21:0]));
			REG_ACCEL_BIAS_Y: p_abias[1] = longint'($signed(val[21:0]));
			REG_ACCEL_BIAS_Z: p_abias[2] = longint'($signed(val[21:0]));
			REG_GYRO_BIAS_X: p_gbias[0] = longint'($signed(val[27:0]));
			REG_GYRO_BIAS_Y: p_gbias[1] = longint'($signed(val[27:0]));
			default: ;
		endcase
	endtask

	function automatic logic [15:0] rand_raw();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'(int'($urandom_range(0, 40)) - 20);
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic add_sample(logic [15:0] ax, ay, az, gx, gy, ms);
		sample_t s;
		s.accel_x = ax; s.accel_y = ay; s.accel_z = az;
		s.gyro_x = gx; s.gyro_y = gy; s.elapsed_ms = ms;
		sample_q.push_back(s);
	endtask

	task automatic add_random(int n);
		for (int i = 0; i < n; i++) begin
			logic [15:0] ms;
			ms = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 40));
			add_sample(rand_raw(), rand_raw(), rand_raw(), rand_raw(), rand_raw(), ms);
		end
	endtask

	function automatic logic [27:0] rand_abias();
		case ($urandom_range(0, 3))
			0: return 28'(-1048576);
			1: return 28'(1048576);
			default: return 28'(int'($urandom_range(0, 2097152)) - 1048576);
		endcase
	endfunction

	function automatic logic [27:0] rand_gbias();
		case ($urandom_range(0, 3))
			0: return 28'(-131072000);
			1: return 28'(131072000);
			default: return 28'($urandom());
		endcase
	endfunction

	initial begin
		p_arange = 0; p_grange = 0; p_alpha = ALPHA_RESET;
		p_abias = '{0, 0, 0}; p_gbias = '{0, 0};
		roll_est = 0; pitch_est = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero numerators, extremes, long steps toward saturation
		add_sample(0, 0, 16'd16384, 0, 0, 10);
		add_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff);
		add_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hffff);
		add_sample(16'h7fff, 0, 0, 16'h7fff, 16'h7fff, 16'hffff);
		add_sample(0, 16'h8000, 0, 16'h8000, 16'h8000, 16'hffff);
		add_sample(0, 0, 0, 1, 16'hffff, 0);
		add_sample(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
		add_sample(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
		add_sample(1, 16'hffff, 1, 0, 0, 1);
		wait_drained();

		// extreme settings: alpha above one, widest ranges, biases at limits
		write_reg(REG_ACCEL_RANGE, 1);
		write_reg(REG_GYRO_RANGE, 3);
		write_reg(REG_BLEND_ALPHA, 28'h1ffff);
		write_reg(REG_ACCEL_BIAS_X, 28'(1048576));
		write_reg(REG_ACCEL_BIAS_Y, 28'(-1048576));
		write_reg(REG_ACCEL_BIAS_Z, 28'(-1048576));
		write_reg(REG_GYRO_BIAS_X, 28'(-131072000));
		write_reg(REG_GYRO_BIAS_Y, 28'(131072000));
		add_sample(0, 0, 0, 16'h7fff, 16'h8000, 16'hffff);
		add_sample(16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'hffff);
		add_random(10);
		// fill the block while the receiver holds off
		hold_cycles <= 400;
		wait_drained();

		write_reg(REG_BLEND_ALPHA, 0);
		write_reg(REG_ACCEL_RANGE, 2);
		write_reg(REG_GYRO_RANGE, 1);
		add_random(6);
		wait_drained();
		write_reg(REG_BLEND_ALPHA, 65536);
		write_reg(REG_GYRO_RANGE, 2);
		add_random(6);
		wait_drained();

		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_ACCEL_RANGE, 28'($urandom_range(0, 3)));
			write_reg(REG_GYRO_RANGE, 28'($urandom_range(0, 3)));
			write_reg(REG_BLEND_ALPHA, (ph == 3) ? 28'd65536 : 28'($urandom_range(0, 131071)));
			write_reg(REG_ACCEL_BIAS_X, rand_abias());
			write_reg(REG_ACCEL_BIAS_Y, rand_abias());
			write_reg(REG_ACCEL_BIAS_Z, rand_abias());
			write_reg(REG_GYRO_BIAS_X, rand_gbias());
			write_reg(REG_GYRO_BIAS_Y, rand_gbias());
			if (ph == 7) quiet = 1;
			add_random(100);
			wait_drained();
		end

		if (errors == 0) begin
			$display("imu_complementary_tilt_filter_tb passed");
		end else begin
			$display("imu_complementary_tilt_filter_tb failed");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("imu_complementary_tilt_filter_tb failed");
		$finish;
	end

endmodule
